FILE: rtl/core/mlrd_pkg.sv
// Shared widths, constants and types for the magic/length ring deframer.
`timescale 1ns / 1ps

package mlrd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int START_W     = 8;
    localparam int MAGIC_W     = 16;
    localparam int HDR_BYTES   = 4;
    localparam int MAX_RUN     = 64;
    localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
    localparam int TDATA_W     = START_W + LEN_W;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET = 16'hAD8E;

    // One found frame: payload length above payload start, as packed on tdata.
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [START_W-1:0] start;
    } frame_t;

endpackage

FILE: rtl/core/magic_length_ring_deframer_top.sv
// Top level of the magic/length ring deframer: byte ring, scan sequencer, result register.
`timescale 1ns / 1ps

//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata[7:0] = rx_byte
//  m_       | out | m_tvalid/m_tready  | m_tdata[7:0] = payload_start,
//           |     |                    | m_tdata[23:8] = payload_length,
//           |     |                    | m_tlast = last_of_run
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_data[15:0] = frame_magic
//
//  Each accepted word starts a scan that reads one header byte per cycle through the
//  registered ring read port. The scan stops on a short ring, skips a byte that holds
//  no magic, stops on an incomplete frame, holds each found frame and flushes the held
//  frame with tlast. Plain noise keeps the scan three bytes behind the write pointer.
//  Reset clears both pointers and restores the frame magic; the ring holds no reset.
//  A full result register with m_tready low stalls the scan; s_tready waits for its end.
module magic_length_ring_deframer_top #(
    parameter int RING_DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave word: [7:0] rx_byte
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mlrd_pkg::BYTE_W-1:0]  s_tdata,
    // master word: [7:0] payload_start, [23:8] payload_length
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mlrd_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    // configuration write: [15:0] frame_magic
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mlrd_pkg::MAGIC_W-1:0] cfg_data
);
    import mlrd_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    // Sum width for pointer + length + header; two spare bits above the larger operand.
    localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 2;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(RING_DEPTH);
    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
    localparam logic [SW-1:0] HDR_S = SW'(HDR_BYTES);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a word
    localparam logic [2:0] ST_CHECK = 3'd1;  // check fill, read magic low byte
    localparam logic [2:0] ST_B0    = 3'd2;  // take magic low byte, read magic high
    localparam logic [2:0] ST_B1    = 3'd3;  // compare magic, read length low
    localparam logic [2:0] ST_B2    = 3'd4;  // take length low, read length high
    localparam logic [2:0] ST_B3    = 3'd5;  // form length, test completeness
    localparam logic [2:0] ST_FOUND = 3'd6;  // retire held frame, hold new one
    localparam logic [2:0] ST_FLUSH = 3'd7;  // send held frame with tlast

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        rp_reg, rp_next;
    logic [AW-1:0]        wp_reg, wp_next;
    logic [MAGIC_W-1:0]   magic_reg;
    logic [RUN_CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [BYTE_W-1:0]    b0_reg, b0_next;
    logic [BYTE_W-1:0]    b2_reg, b2_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    frame_t               pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    frame_t               out_reg, out_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]    ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0]    ring_rd_reg;
    logic [AW-1:0]        rd_addr;
    logic [1:0]           rd_off;
    logic                 wr_en;

    logic [AW:0]          used;
    logic [AW:0]          used_diff;
    logic                 out_free;
    logic [LEN_W-1:0]     len_now;
    logic [SW-1:0]        need_s;
    logic [SW-1:0]        adv_sum;
    logic [AW-1:0]        adv_rp;
    logic [AW-1:0]        payload_idx;
    logic [AW+BYTE_W-1:0] start_ext;
    logic [2:0]           stop_state;

    // Add a small offset to a ring index, wrapping once at the ring depth.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [2:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW + 1)'(off);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign m_tlast   = out_last_reg;

    assign wr_en    = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Fill level, modulo the ring depth
    assign used_diff = {1'b0, wp_reg} - {1'b0, rp_reg};
    assign used      = (wp_reg >= rp_reg) ? used_diff : (used_diff + DEPTH_W);

    // Length header, little endian; valid in ST_B3 while the high byte is on the port
    assign len_now = {ring_rd_reg, b2_reg};
    assign need_s  = SW'(len_now) + HDR_S;

    // Skip past the whole frame; the frame fits in the ring so one wrap is enough
    always_comb
    begin
        adv_sum = SW'(rp_reg) + SW'(len_reg) + HDR_S;
        if (adv_sum >= DEPTH_S)
        begin
            adv_sum = adv_sum - DEPTH_S;
        end
        adv_rp = adv_sum[AW-1:0];
    end

    assign payload_idx = ring_add(rp_reg, 3'(HDR_BYTES));
    assign start_ext   = {{BYTE_W{1'b0}}, payload_idx};

    assign stop_state = pend_valid_reg ? ST_FLUSH : ST_IDLE;

    // Read offset from the read pointer for the byte requested this cycle
    always_comb
    begin
        unique case (state_reg)
            ST_B0:   rd_off = 2'd1;
            ST_B1:   rd_off = 2'd2;
            ST_B2:   rd_off = 2'd3;
            default: rd_off = 2'd0;
        endcase
    end
    assign rd_addr = ring_add(rp_reg, {1'b0, rd_off});

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wp_reg] <= s_tdata;
        end
        ring_rd_reg <= ring_mem[rd_addr];
    end

    // Scan sequencer
    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        run_cnt_next    = run_cnt_reg;
        b0_next         = b0_reg;
        b2_next         = b2_reg;
        len_next        = len_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (wr_en)
                begin
                    wp_next      = ring_add(wp_reg, 3'd1);
                    run_cnt_next = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Stop on a short ring or a full run
                if ((used < (AW + 1)'(HDR_BYTES)) || (run_cnt_reg == RUN_CNT_W'(MAX_RUN)))
                begin
                    state_next = stop_state;
                end
                else
                begin
                    state_next = ST_B0;
                end
            end
            ST_B0:
            begin
                b0_next    = ring_rd_reg;
                state_next = ST_B1;
            end
            ST_B1:
            begin
                // No magic here: drop one byte and rescan
                if ({ring_rd_reg, b0_reg} != magic_reg)
                begin
                    rp_next    = ring_add(rp_reg, 3'd1);
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_B2;
                end
            end
            ST_B2:
            begin
                b2_next    = ring_rd_reg;
                state_next = ST_B3;
            end
            ST_B3:
            begin
                len_next = len_now;
                // Wait for more bytes if the payload is not all here
                if (SW'(used) < need_s)
                begin
                    state_next = stop_state;
                end
                else
                begin
                    state_next = ST_FOUND;
                end
            end
            ST_FOUND:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    pend_next.start = start_ext[START_W-1:0];
                    pend_next.len   = len_reg;
                    pend_valid_next = 1'b1;
                    run_cnt_next    = run_cnt_reg + 1'b1;
                    rp_next         = adv_rp;
                    state_next      = ST_CHECK;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            run_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            magic_reg      <= MAGIC_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            run_cnt_reg    <= run_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                magic_reg <= cfg_data;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        b0_reg       <= b0_next;
        b2_reg       <= b2_next;
        len_reg      <= len_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: rtl/core/mlrd_checker.sv
// Port-level checks for the magic/length ring deframer, bound to the top level.
`timescale 1ns / 1ps

module mlrd_checker #(
    parameter int RING_DEPTH = 256
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mlrd_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tlast
);
    import mlrd_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

    // The scan is busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready during scan");

    // A run that is not closed keeps the input stalled
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready with an open run");

    // A whole frame fits in the ring, so its length stays below the depth
    a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[TDATA_W-1:START_W]) <= 32'(RING_DEPTH - HDR_BYTES)))
        else $error("payload length exceeds ring");

endmodule

bind magic_length_ring_deframer_top mlrd_checker #(
    .RING_DEPTH(RING_DEPTH)
) u_mlrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
